[rtl/core/lppid_pkg.sv]
// ============================================================================
// lppid_pkg
// Shared types and constants of the lift position PID controller with a
// full drive zone.
// ============================================================================
package lppid_pkg;

    // Widths of the configuration registers.
    localparam int GAIN_W  = 16;
    localparam int THR_W   = 23;
    localparam int CAP_W   = 24;
    localparam int LIM_W   = 24;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Result format.
    localparam int DRIVE_W = 8;
    localparam int MAG_W   = 7;
    localparam int FRAC_W  = 16;
    localparam logic [MAG_W-1:0] FULL_DRIVE = 7'd127;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]       GAIN_P_RST = 16'd328;
    localparam logic [GAIN_W-1:0]       GAIN_I_RST = 16'd0;
    localparam logic [GAIN_W-1:0]       GAIN_D_RST = 16'd655;
    localparam logic [THR_W-1:0]        FULL_THR_RST = 23'd2000;
    localparam logic [THR_W-1:0]        DEAD_ZONE_RST = 23'd500;
    localparam logic [CAP_W-1:0]        INT_CAP_RST = 24'd10000;
    localparam logic signed [LIM_W-1:0] LOW_LIMIT_RST = 24'sd1000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_FULL_THR  = 3'd3,
        CFG_DEAD_ZONE = 3'd4,
        CFG_INT_CAP   = 3'd5,
        CFG_LOW_LIMIT = 3'd6
    } lppid_cfg_idx_t;

    // Decisions made in the front stage that steer the result stage.
    typedef struct packed {
        logic full;       // error above the full drive threshold
        logic force_zero; // low target inside the dead zone
        logic dir_pos;    // target above measured position
        logic dir_neg;    // target below measured position
    } lppid_flags_t;

endpackage

[rtl/core/lift_position_pid_with_bang_bang_core.sv]
// ============================================================================
// lift_position_pid_with_bang_bang_core
// Lift position PID controller with a full drive zone and a dead zone.
// ============================================================================
// Usage:
// Each input transfer carries a command (0 = control tick, 1 = restart then
// tick), a target and a measured position; each one yields exactly one
// output transfer carrying the signed motor drive in -127..127.
// Both channels use valid/stall: a transfer happens on a rising edge with
// valid high and stall low; it takes one transfer per cycle unless stalled.
// From input transfer to output valid, the first stage works out the error
// and updates the integral state, and the second stage forms the weighted
// PID sum, applies the direction and saturates.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single pass through each stage; the integral update fits in the first
// stage, so consecutive ticks follow each other without waiting.
// When the receiver stalls, the whole pipeline holds and in_stall is raised
// while a finished result waits; the held result stays stable. Reset clears
// the integral, last error and integral zone, empties the pipeline and loads
// the configuration registers with their defaults. Configuration is written
// via cfg_we/cfg_index/cfg_data, by the user only while idle; not enforced.
// ============================================================================
module lift_position_pid_with_bang_bang_core
    import lppid_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic signed [POS_WIDTH-1:0]   target_pos,
    input  logic signed [POS_WIDTH-1:0]   measured_pos,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DRIVE_W-1:0]     drive,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic [GAIN_W-1:0]          gain_p_reg;
    logic [GAIN_W-1:0]          gain_i_reg;
    logic [GAIN_W-1:0]          gain_d_reg;
    logic [THR_W-1:0]           full_thr_reg;
    logic [THR_W-1:0]           dead_zone_reg;
    logic [CAP_W-1:0]           int_cap_reg;
    logic signed [LIM_W-1:0]    low_limit_reg;

    logic                       s1_valid_reg;
    logic                       advance;
    logic                       accept;

    logic [POS_WIDTH:0]          p_term;
    logic [CAP_W-1:0]            i_term;
    logic signed [POS_WIDTH+1:0] d_term;
    lppid_flags_t                flags;

    // The pipeline moves whenever the output register is empty or its
    // result is being taken this cycle.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            full_thr_reg  <= FULL_THR_RST;
            dead_zone_reg <= DEAD_ZONE_RST;
            int_cap_reg   <= INT_CAP_RST;
            low_limit_reg <= LOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                CFG_FULL_THR:  full_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[THR_W-1:0];
                CFG_INT_CAP:   int_cap_reg   <= cfg_data[CAP_W-1:0];
                CFG_LOW_LIMIT: low_limit_reg <= $signed(cfg_data[LIM_W-1:0]);
                default:       ;
            endcase
        end
    end

    // Valid bit of the operand stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    lppid_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .advance      (advance),
        .command      (command),
        .target_pos   (target_pos),
        .measured_pos (measured_pos),
        .full_thr     (full_thr_reg),
        .dead_zone    (dead_zone_reg),
        .int_cap      (int_cap_reg),
        .low_limit    (low_limit_reg),
        .p_term       (p_term),
        .i_term       (i_term),
        .d_term       (d_term),
        .flags        (flags)
    );

    lppid_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_valid  (s1_valid_reg),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .p_term    (p_term),
        .i_term    (i_term),
        .d_term    (d_term),
        .flags     (flags),
        .out_valid (out_valid),
        .drive     (drive)
    );

endmodule

[rtl/core/lppid_front.sv]
// ============================================================================
// lppid_front
// Error stage: computes the error magnitude and direction, updates the
// integral, last error and integral zone state, and registers the PID
// operands for the result stage.
// ============================================================================
module lppid_front
    import lppid_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          advance,
    input  logic                          command,
    input  logic signed [POS_WIDTH-1:0]   target_pos,
    input  logic signed [POS_WIDTH-1:0]   measured_pos,
    input  logic [THR_W-1:0]              full_thr,
    input  logic [THR_W-1:0]              dead_zone,
    input  logic [CAP_W-1:0]              int_cap,
    input  logic signed [LIM_W-1:0]       low_limit,
    output logic [POS_WIDTH:0]            p_term,
    output logic [CAP_W-1:0]              i_term,
    output logic signed [POS_WIDTH+1:0]   d_term,
    output lppid_flags_t                  flags
);

    localparam int ERR_W  = POS_WIDTH + 1;
    localparam int DIF_W  = POS_WIDTH + 2;
    localparam int ZONE_W = POS_WIDTH - 1;
    localparam int CMP_W  = ((ERR_W > CAP_W) ? ERR_W : CAP_W) + 1;
    localparam int LW     = (POS_WIDTH > LIM_W) ? POS_WIDTH : LIM_W;

    logic signed [DIF_W-1:0]  t_x;
    logic signed [DIF_W-1:0]  m_x;
    logic signed [DIF_W-1:0]  abs_t;
    logic signed [DIF_W-1:0]  abs_m;
    logic signed [DIF_W-1:0]  err_dif;
    logic signed [DIF_W-1:0]  dir_dif;
    logic signed [DIF_W-1:0]  mag_dif;
    logic [DIF_W-1:0]         err_abs;
    logic [DIF_W-1:0]         mag_abs;
    logic [DIF_W-1:0]         zone_sum;
    logic [ERR_W-1:0]         err;
    logic [ZONE_W-1:0]        zone_new;

    logic [CAP_W-1:0]         acc_reg;
    logic [CAP_W-1:0]         acc_next;
    logic [ERR_W-1:0]         prev_reg;
    logic [ERR_W-1:0]         prev_next;
    logic [ZONE_W-1:0]        zone_reg;
    logic [ZONE_W-1:0]        zone_next;

    logic [CAP_W-1:0]         acc_eff;
    logic [ERR_W-1:0]         prev_eff;
    logic [ZONE_W-1:0]        zone_eff;
    logic [CMP_W-1:0]         acc_sum;
    logic                     in_zone;
    logic                     in_dead;
    logic                     is_full;
    logic                     low_target;
    logic signed [LW-1:0]     t_l;
    logic signed [LW-1:0]     lim_l;
    logic signed [DIF_W-1:0]  dv;

    logic [ERR_W-1:0]          p_reg;
    logic signed [DIF_W-1:0]   d_reg;
    lppid_flags_t              flags_reg;
    lppid_flags_t              flags_next;

    // Error magnitude |target - |measured|| and direction target - measured.
    always_comb
    begin
        t_x      = DIF_W'(target_pos);
        m_x      = DIF_W'(measured_pos);
        abs_t    = (t_x < 0) ? -t_x : t_x;
        abs_m    = (m_x < 0) ? -m_x : m_x;
        err_dif  = t_x - abs_m;
        err_abs  = (err_dif < 0) ? DIF_W'(-err_dif) : DIF_W'(err_dif);
        err      = err_abs[ERR_W-1:0];
        dir_dif  = t_x - m_x;
        mag_dif  = abs_t - abs_m;
        mag_abs  = (mag_dif < 0) ? DIF_W'(-mag_dif) : DIF_W'(mag_dif);
        // Ceiling of a quarter of the magnitude difference.
        zone_sum = mag_abs + DIF_W'(3);
        zone_new = zone_sum[ZONE_W+1:2];
    end

    // State update for one transfer.
    always_comb
    begin
        acc_eff    = command ? '0 : acc_reg;
        prev_eff   = command ? '0 : prev_reg;
        zone_eff   = command ? zone_new : zone_reg;

        is_full    = CMP_W'(err) > CMP_W'(full_thr);
        in_zone    = CMP_W'(err) < CMP_W'(zone_eff);
        in_dead    = CMP_W'(err) < CMP_W'(dead_zone);
        acc_sum    = CMP_W'(acc_eff) + CMP_W'(err);

        t_l        = LW'(target_pos);
        lim_l      = LW'(low_limit);
        low_target = t_l < lim_l;

        if (!in_zone)
        begin
            acc_next = '0;
        end
        else if (acc_sum > CMP_W'(int_cap))
        begin
            acc_next = int_cap;
        end
        else
        begin
            acc_next = acc_sum[CAP_W-1:0];
        end

        dv        = DIF_W'(err) - DIF_W'(prev_eff);
        prev_next = err;
        zone_next = zone_eff;

        // The full drive branch leaves the integral and last error alone.
        if (is_full)
        begin
            acc_next  = acc_eff;
            prev_next = prev_eff;
        end

        flags_next.full       = is_full;
        flags_next.force_zero = low_target && in_dead;
        flags_next.dir_pos    = dir_dif > 0;
        flags_next.dir_neg    = dir_dif < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
            zone_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
            zone_reg <= zone_next;
        end
    end

    // Operand registers; P and D are zeroed inside the dead zone.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg     <= in_dead ? '0 : err;
            d_reg     <= in_dead ? '0 : dv;
            flags_reg <= flags_next;
        end
    end

    assign p_term = p_reg;
    assign i_term = acc_reg;
    assign d_term = d_reg;
    assign flags  = flags_reg;

endmodule

[rtl/core/lppid_back.sv]
// ============================================================================
// lppid_back
// Result stage: weights the PID operands by the gains, applies the
// direction, saturates to the drive range and holds the result register.
// ============================================================================
module lppid_back
    import lppid_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          s1_valid,
    input  logic [GAIN_W-1:0]             gain_p,
    input  logic [GAIN_W-1:0]             gain_i,
    input  logic [GAIN_W-1:0]             gain_d,
    input  logic [POS_WIDTH:0]            p_term,
    input  logic [CAP_W-1:0]              i_term,
    input  logic signed [POS_WIDTH+1:0]   d_term,
    input  lppid_flags_t                  flags,
    output logic                          out_valid,
    output logic signed [DRIVE_W-1:0]     drive
);

    localparam int PP_W = POS_WIDTH + 1 + GAIN_W;
    localparam int PI_W = CAP_W + GAIN_W;
    localparam int PD_W = POS_WIDTH + 3 + GAIN_W;
    localparam int SW   = ((PD_W > PI_W) ? PD_W : PI_W) + 2;

    logic [PP_W-1:0]          prod_p;
    logic [PI_W-1:0]          prod_i;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [SW-1:0]     sum;
    logic [SW-1:0]            sum_abs;
    logic [SW-FRAC_W-1:0]     whole;
    logic [MAG_W-1:0]         q;
    logic                     neg;
    logic signed [DRIVE_W-1:0] drive_next;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    always_comb
    begin
        prod_p  = PP_W'(gain_p) * PP_W'(p_term);
        prod_i  = PI_W'(gain_i) * PI_W'(i_term);
        prod_d  = $signed({1'b0, gain_d}) * PD_W'(d_term);
        sum     = $signed(SW'(prod_p)) + $signed(SW'(prod_i)) + SW'(prod_d);
        sum_abs = (sum < 0) ? SW'(-sum) : SW'(sum);
        whole   = sum_abs[SW-1:FRAC_W];
        q       = (whole > (SW-FRAC_W)'(FULL_DRIVE)) ? FULL_DRIVE : whole[MAG_W-1:0];
        // Multiplying by a negative direction flips the sign of the sum.
        neg     = (sum < 0) ^ flags.dir_neg;

        if (flags.full)
        begin
            drive_next = flags.dir_pos ? $signed({1'b0, FULL_DRIVE})
                                       : -$signed({1'b0, FULL_DRIVE});
        end
        else if (!flags.dir_pos && !flags.dir_neg)
        begin
            drive_next = '0;
        end
        else
        begin
            drive_next = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end

        if (flags.force_zero)
        begin
            drive_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

[tb/lppid_drive_checker.sv]
// ============================================================================
// lppid_drive_checker
// Predicts the motor drive for every input transfer of the lift position
// controller and compares it with each output transfer, in order.
// ============================================================================
module lppid_drive_checker
    import lppid_pkg::*;
#(
    parameter int POS_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        command,
    input  logic signed [POS_WIDTH-1:0] target_pos,
    input  logic signed [POS_WIDTH-1:0] measured_pos,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [DRIVE_W-1:0]   drive,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          mismatches,
    output int                          pending,
    output int                          checked
);

    // Shadow copy of the configuration registers.
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic [GAIN_W-1:0]       kd;
    logic [THR_W-1:0]        full_thr;
    logic [THR_W-1:0]        dead_band;
    logic [CAP_W-1:0]        int_cap;
    logic signed [LIM_W-1:0] low_limit;

    // Controller state: integral sum, error of the last PID tick, zone.
    longint                  integ_sum;
    longint                  last_err;
    longint                  int_zone;

    logic signed [DRIVE_W-1:0] drive_queue[$];
    int                        fail_count;
    int                        result_count;

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Advances the controller state by one tick and returns its drive.
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic                        restart,
        input logic signed [POS_WIDTH-1:0] tgt,
        input logic signed [POS_WIDTH-1:0] pos
    );
        longint t;
        longint m;
        longint err;
        longint diff;
        longint acc;
        longint p_term;
        longint d_term;
        longint sum;
        longint q;
        longint res;

        t    = longint'(tgt);
        m    = longint'(pos);
        err  = magnitude(t - magnitude(m));
        diff = t - m;

        if (restart)
        begin
            integ_sum = 0;
            last_err  = 0;
            int_zone  = (magnitude(magnitude(t) - magnitude(m)) + 3) / 4;
        end

        if (err > longint'(full_thr))
        begin
            res = (diff > 0) ? 127 : -127;
        end
        else
        begin
            acc = (err < int_zone) ? integ_sum + err : 0;
            if (acc > longint'(int_cap))
                acc = longint'(int_cap);
            integ_sum = acc;

            d_term   = err - last_err;
            last_err = err;
            p_term   = err;
            if (err < longint'(dead_band))
            begin
                p_term = 0;
                d_term = 0;
            end

            sum = longint'(kp) * p_term + longint'(ki) * acc + longint'(kd) * d_term;
            if (diff < 0)
                sum = -sum;
            else if (diff == 0)
                sum = 0;

            q = magnitude(sum) >>> FRAC_W;
            if (q > 127)
                q = 127;
            res = (sum < 0) ? -q : q;
        end

        if (t < longint'(low_limit) && err < longint'(dead_band))
            res = 0;

        return res[DRIVE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp           = GAIN_P_RST;
            ki           = GAIN_I_RST;
            kd           = GAIN_D_RST;
            full_thr     = FULL_THR_RST;
            dead_band    = DEAD_ZONE_RST;
            int_cap      = INT_CAP_RST;
            low_limit    = LOW_LIMIT_RST;
            integ_sum    = 0;
            last_err     = 0;
            int_zone     = 0;
            drive_queue.delete();
            fail_count   = 0;
            result_count = 0;
            mismatches   <= 0;
            pending      <= 0;
            checked      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (lppid_cfg_idx_t'(cfg_index))
                    CFG_GAIN_P:    kp        = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:    ki        = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:    kd        = cfg_data[GAIN_W-1:0];
                    CFG_FULL_THR:  full_thr  = cfg_data[THR_W-1:0];
                    CFG_DEAD_ZONE: dead_band = cfg_data[THR_W-1:0];
                    CFG_INT_CAP:   int_cap   = cfg_data[CAP_W-1:0];
                    CFG_LOW_LIMIT: low_limit = $signed(cfg_data[LIM_W-1:0]);
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                result_count++;
                if (drive_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("drive %0d arrived with no tick outstanding", drive);
                end
                else
                begin
                    if (drive !== drive_queue[0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("drive mismatch on result %0d: expected %0d, got %0d",
                                     result_count, drive_queue[0], drive);
                    end
                    void'(drive_queue.pop_front());
                end
            end

            if (in_valid && !in_stall)
                drive_queue.push_back(predict_drive(command, target_pos, measured_pos));

            mismatches <= fail_count;
            pending    <= drive_queue.size();
            checked    <= result_count;
        end
    end

endmodule

[tb/lift_position_pid_with_bang_bang_core_tb.sv]
// ============================================================================
// lift_position_pid_with_bang_bang_core_tb
// Self-checking bench for the lift position PID controller with full drive.
// A directed set of corner ticks runs at the reset configuration, followed
// by random control sequences under ten register settings and four idle
// and stall patterns; a separate checker predicts every drive value.
// ============================================================================
module lift_position_pid_with_bang_bang_core_tb;
    import lppid_pkg::*;

    localparam int POS_W           = 24;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 124;
    // The pipeline is two stages deep; the drain wait covers the tail.
    localparam int DRAIN_CYCLES    = 8;
    // Longest gap without any transfer that a correct run can show, with
    // a wide margin over the worst random idle or stall streak.
    localparam int WATCHDOG_LIMIT  = 3000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic signed [POS_W-1:0]  target_pos;
    logic signed [POS_W-1:0]  measured_pos;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] drive;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int mismatches;
    int pending;
    int checked;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles;
    int sent_items    = 0;
    int directed_items;

    // State of the random control sequence: a target that is being
    // approached and the remaining offset of the measured position from it.
    longint thr_now    = longint'(FULL_THR_RST);
    longint seq_target = 0;
    longint seq_offset = 0;

    lift_position_pid_with_bang_bang_core #(
        .POS_WIDTH (POS_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .target_pos   (target_pos),
        .measured_pos (measured_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lppid_drive_checker #(
        .POS_WIDTH (POS_W)
    ) drive_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .target_pos   (target_pos),
        .measured_pos (measured_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random; the rate follows the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: ends the run if no transfer happens for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Presents one tick on the input channel and holds it until the
    // transfer takes place. A random number of idle cycles may come first.
    task automatic send_item(input logic cmd, input longint tgt, input longint pos);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        target_pos   <= tgt[POS_W-1:0];
        measured_pos <= pos[POS_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // Stops sending and waits until every predicted drive has come back,
    // then lets the pipeline settle. Pending is registered in the checker,
    // so it is first looked at only after the checker has updated it.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lppid_cfg_idx_t idx, input longint value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // Writes all seven registers. The first phases use fixed settings that
    // include both extremes of every register; later phases are random.
    task automatic load_settings(input int phase);
        longint gp;
        longint gi;
        longint gd;
        longint thr;
        longint dz;
        longint cap;
        longint lim;

        case (phase)
            0:
            begin
                gp = 328;   gi = 40;    gd = 655;
                thr = 2000; dz = 500;   cap = 10000; lim = 1000;
            end
            1:
            begin
                gp = 65535;   gi = 65535;   gd = 65535;
                thr = 8388607; dz = 8388607; cap = 16777215; lim = 8388607;
            end
            2:
            begin
                gp = 0;   gi = 0;  gd = 0;
                thr = 0;  dz = 0;  cap = 0; lim = -8388608;
            end
            3:
            begin
                gp = 65535;    gi = 65535; gd = 65535;
                thr = 8388607; dz = 0;     cap = 3000; lim = -8388608;
            end
            default:
            begin
                gp  = ($urandom_range(3) == 0) ? longint'($urandom_range(65535))
                                               : longint'($urandom_range(4000));
                gi  = longint'($urandom_range(300));
                gd  = ($urandom_range(3) == 0) ? longint'($urandom_range(65535))
                                               : longint'($urandom_range(6000));
                thr = longint'($urandom_range(20000, 100));
                dz  = longint'($urandom_range(int'(thr)));
                cap = longint'($urandom_range(200000));
                lim = longint'($urandom_range(40000)) - 20000;
            end
        endcase

        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_FULL_THR, thr);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_INT_CAP, cap);
        write_reg(CFG_LOW_LIMIT, lim);
        cfg_we  <= 1'b0;
        thr_now  = thr;
    endtask

    // Most random ticks follow a lift move: a restart with a fresh target
    // and a distant position, then ticks whose position closes in on the
    // target so that the run passes through the full drive zone, the PID
    // zone, the integral zone and the dead band. Some ticks negate the
    // measured position; a few are pure noise.
    task automatic send_random_item();
        int     r;
        logic   restart;
        longint span;
        longint pos;

        r = $urandom_range(99);
        if (r < 8)
        begin
            send_item(1'($urandom_range(1)), longint'($urandom), longint'($urandom));
        end
        else
        begin
            restart = (r >= 94);
            if (restart)
            begin
                if ($urandom_range(1) == 1)
                    seq_target = longint'($urandom_range(16777215)) - 8388608;
                else
                    seq_target = longint'($urandom_range(60000)) - 30000;
                span = 4 * thr_now + 1000;
                if (span > 30000000)
                    span = 30000000;
                seq_offset = longint'($urandom_range(int'(2 * span))) - span;
            end
            else
            begin
                seq_offset = seq_offset * longint'($urandom_range(100, 40)) / 100
                           + longint'($urandom_range(40)) - 20;
            end
            pos = seq_target - seq_offset;
            if ($urandom_range(9) == 0)
                pos = -pos;
            send_item(restart, seq_target, pos);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = 1'b0;
        target_pos   = '0;
        measured_pos = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_GAIN_P;
        cfg_data     = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at the reset configuration.
        send_item(1'b1, 5000, 0);             // restart far away: full forward drive
        send_item(1'b0, 3000, 3000);          // equal positions in the PID zone
        send_item(1'b0, -5000, -5000);        // equal positions but full drive branch
        send_item(1'b0, 8388607, -8388608);   // field extremes, tiny error
        send_item(1'b0, -8388608, 8388607);
        send_item(1'b0, -8388608, -8388608);  // largest error, no direction
        send_item(1'b1, 0, 0);                // restart with an empty integral zone
        send_item(1'b1, 4000, 1000);          // restart that opens an integral zone
        send_item(1'b0, 4000, 3500);          // inside the zone, at the dead band edge
        send_item(1'b0, 4000, 3800);          // inside the zone and the dead band
        send_item(1'b0, 4000, 3999);
        send_item(1'b0, 500, 400);            // low target inside the dead band
        send_item(1'b0, 100, -150);           // negative measured position
        send_item(1'b0, 2000, 0);             // error right at the threshold
        send_item(1'b0, 2001, 0);             // error just above the threshold
        send_item(1'b0, 1500, 1000);          // error right at the dead band
        send_item(1'b0, -1500, 1000);         // full reverse drive
        send_item(1'b1, 8388607, 8388607);
        send_item(1'b1, -8388608, 0);
        directed_items = sent_items;

        // Random phases: every fourth phase has no idling at all, the others
        // idle the sender, stall the receiver, or lightly do both.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            load_settings(phase);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 85; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        wait_idle();

        $display("Sent %0d directed and %0d random ticks over %0d register settings;",
                 directed_items, sent_items - directed_items, PHASES + 1);
        $display("%0d drive values compared, %0d mismatches.", checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
